>>> design/dnv_pkg.sv
// Package for the domain name validator: word class record, verdict codes,
// configuration indexes and the reserved-word tables.
// No dependencies.
`default_nettype none

package dnv_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_NAME  = 3'd0;
  localparam logic [2:0] CFG_MAX_LABEL = 3'd1;
  localparam logic [2:0] CFG_MAX_DOTS  = 3'd2;
  localparam logic [2:0] CFG_MAX_DRUN  = 3'd3;
  localparam logic [2:0] CFG_MAX_TLD   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] MAX_NAME_RST  = 8'd253;
  localparam logic [6:0] MAX_LABEL_RST = 7'd63;
  localparam logic [3:0] MAX_DOTS_RST  = 4'd10;
  localparam logic [3:0] MAX_DRUN_RST  = 4'd8;
  localparam logic [5:0] MAX_TLD_RST   = 6'd20;

  // Fixed upper bound on the final label length
  localparam logic [7:0] TLD_HARD_MAX  = 8'd63;

  localparam int RSV_WORDS = 6;

  typedef enum logic [3:0] {
    RSN_OK         = 4'd0,
    RSN_LENGTH     = 4'd1,
    RSN_EDGE       = 4'd2,
    RSN_LABEL      = 4'd3,
    RSN_DOTS       = 4'd4,
    RSN_RESERVED   = 4'd5,
    RSN_SUSPICIOUS = 4'd6,
    RSN_TLD        = 4'd7,
    RSN_BAD_CHAR   = 4'd8
  } reason_e;

  typedef struct packed {
    logic [7:0] max_name;
    logic [6:0] max_label;
    logic [3:0] max_dots;
    logic [3:0] max_drun;
    logic [5:0] max_tld;
  } cfg_t;

  // One classified word as it travels through the queue
  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_last;
    logic       is_dot;
    logic       is_hyphen;
    logic       is_letter;
    logic       is_digit;
    logic       non_ascii;
    logic       bad_char;
  } item_t;

  // Reserved word w, left-aligned in 10 bytes, zero padded
  function automatic logic [79:0] rsv_word(input logic [2:0] w);
    logic [79:0] s;
    case (w)
      3'd0:    s = {"localhost", 8'h00};
      3'd1:    s = {"local", 40'h0};
      3'd2:    s = {"test", 48'h0};
      3'd3:    s = {"invalid", 24'h0};
      3'd4:    s = {"example", 24'h0};
      3'd5:    s = {"onion", 40'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] rsv_len(input logic [2:0] w);
    logic [3:0] n;
    case (w)
      3'd0:    n = 4'd9;
      3'd1:    n = 4'd5;
      3'd2:    n = 4'd4;
      3'd3:    n = 4'd7;
      3'd4:    n = 4'd7;
      3'd5:    n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Byte k of reserved word w (zero past its end)
  function automatic logic [7:0] rsv_char(input logic [2:0] w, input logic [3:0] k);
    logic [79:0] s;
    s = rsv_word(w) << {k, 3'b000};
    return s[79:72];
  endfunction

endpackage

`default_nettype wire

>>> design/dnv_front.sv
// Front end of the domain name validator: takes input words and classifies
// each byte before it enters the queue. Depends on dnv_pkg.
`default_nettype none

module dnv_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    name_byte_i,
  input  logic          is_last_i,
  input  logic          q_full_i,
  output logic          push_o,
  output dnv_pkg::item_t item_o
);
  import dnv_pkg::*;

  logic letter, digit, dot, hyphen;

  // Byte classes, ASCII only
  assign letter = ((name_byte_i >= 8'h61) && (name_byte_i <= 8'h7A)) ||
                  ((name_byte_i >= 8'h41) && (name_byte_i <= 8'h5A));
  assign digit  = (name_byte_i >= 8'h30) && (name_byte_i <= 8'h39);
  assign dot    = (name_byte_i == 8'h2E);
  assign hyphen = (name_byte_i == 8'h2D);

  always_comb begin
    item_o.name_byte = name_byte_i;
    item_o.is_last   = is_last_i;
    item_o.is_dot    = dot;
    item_o.is_hyphen = hyphen;
    item_o.is_letter = letter;
    item_o.is_digit  = digit;
    item_o.non_ascii = name_byte_i[7];
    item_o.bad_char  = !letter && !digit && !hyphen && !dot;
  end

  // Accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

>>> design/dnv_queue.sv
// Two-entry queue of classified words between front and back end.
// Depends on dnv_pkg.
`default_nettype none

module dnv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dnv_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output dnv_pkg::item_t pop_item_o
);
  import dnv_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> design/dnv_back.sv
// Back end of the domain name validator: running counters, sticky flags,
// verdict and the output register. Depends on dnv_pkg.
`default_nettype none

module dnv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dnv_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  dnv_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           name_valid_o,
  output logic [3:0]     fail_reason_o
);
  import dnv_pkg::*;

  // Running state
  logic [7:0] name_len_q, name_len_d;
  logic [7:0] label_len_q, label_len_d;
  logic [3:0] dot_cnt_q, dot_cnt_d;
  logic [3:0] drun_q, drun_d;
  logic [3:0] drun_max_q, drun_max_d;
  logic       saw_dot_q, saw_dot_d;
  logic       lbl_letters_q, lbl_letters_d;
  logic       all_digits_q, all_digits_d;
  logic [RSV_WORDS-1:0] rsv_q, rsv_d;
  logic       edge_q, edge_d;
  logic       strct_q, strct_d;
  logic       strct_dots_q, strct_dots_d;
  logic       non_ascii_q, non_ascii_d;
  logic       bad_q, bad_d;
  logic       prev_dot_q, prev_dot_d;

  // Output register
  logic       out_valid_q;
  logic       name_valid_q;
  reason_e    reason_q, reason_d;

  logic       lbl_fail_dot, dot_fail, fin_strct, fin_dots, reserved_hit;

  assign pop_o = q_valid_i && (!item_i.is_last || !out_valid_q || out_ready_i);

  // Next state for the word at the head of the queue
  always_comb begin
    name_len_d    = (name_len_q == 8'd255) ? name_len_q : name_len_q + 8'd1;
    label_len_d   = label_len_q;
    dot_cnt_d     = dot_cnt_q;
    drun_d        = drun_q;
    drun_max_d    = drun_max_q;
    saw_dot_d     = saw_dot_q;
    lbl_letters_d = lbl_letters_q;
    all_digits_d  = all_digits_q;
    rsv_d         = rsv_q;
    edge_d        = edge_q | ((name_len_q == 8'd0) && (item_i.is_dot || item_i.is_hyphen));
    strct_d       = strct_q;
    strct_dots_d  = strct_dots_q;
    non_ascii_d   = non_ascii_q;
    bad_d         = bad_q;
    prev_dot_d    = item_i.is_dot;
    lbl_fail_dot  = (label_len_q == 8'd0) || (label_len_q > {1'b0, cfg_i.max_label});
    dot_fail      = 1'b0;

    if (item_i.is_dot) begin
      label_len_d   = 8'd0;
      dot_cnt_d     = (dot_cnt_q == 4'd15) ? dot_cnt_q : dot_cnt_q + 4'd1;
      dot_fail      = dot_cnt_d > cfg_i.max_dots;
      // label check first, then dot count
      if (!strct_q && lbl_fail_dot) begin
        strct_d = 1'b1;
      end else if (!strct_q && dot_fail) begin
        strct_d      = 1'b1;
        strct_dots_d = 1'b1;
      end
      drun_d        = 4'd0;
      saw_dot_d     = 1'b1;
      lbl_letters_d = 1'b1;
      rsv_d         = '1;
      if (prev_dot_q) bad_d = 1'b1;
    end else begin
      for (int i = 0; i < RSV_WORDS; i++) begin
        if ((label_len_q >= {4'd0, rsv_len(3'(i))}) ||
            (rsv_char(3'(i), label_len_q[3:0]) != item_i.name_byte)) begin
          rsv_d[i] = 1'b0;
        end
      end
      label_len_d = (label_len_q == 8'd255) ? label_len_q : label_len_q + 8'd1;
      if (item_i.is_digit) begin
        drun_d = (drun_q == 4'd15) ? drun_q : drun_q + 4'd1;
        if (drun_d > drun_max_q) drun_max_d = drun_d;
      end else begin
        all_digits_d = 1'b0;
        drun_d       = 4'd0;
      end
      if (!item_i.is_letter) lbl_letters_d = 1'b0;
      if (item_i.non_ascii)  non_ascii_d   = 1'b1;
      if (item_i.bad_char)   bad_d         = 1'b1;
    end
  end

  // Verdict from the updated state
  always_comb begin
    fin_strct = strct_d;
    fin_dots  = strct_dots_d;
    if (!strct_d && ((label_len_d == 8'd0) || (label_len_d > {1'b0, cfg_i.max_label}))) begin
      fin_strct = 1'b1;
      fin_dots  = 1'b0;
    end
    reserved_hit = 1'b0;
    for (int i = 0; i < RSV_WORDS; i++) begin
      if (rsv_d[i] && (label_len_d == {4'd0, rsv_len(3'(i))})) reserved_hit = 1'b1;
    end

    if (name_len_d > cfg_i.max_name) begin
      reason_d = RSN_LENGTH;
    end else if (edge_d || item_i.is_dot || item_i.is_hyphen) begin
      reason_d = RSN_EDGE;
    end else if (fin_strct) begin
      reason_d = fin_dots ? RSN_DOTS : RSN_LABEL;
    end else if (reserved_hit) begin
      reason_d = RSN_RESERVED;
    end else if (non_ascii_d || all_digits_d || (drun_max_d > cfg_i.max_drun)) begin
      reason_d = RSN_SUSPICIOUS;
    end else if (saw_dot_d && ((label_len_d < 8'd2) || (label_len_d > TLD_HARD_MAX) ||
                               !lbl_letters_d || (label_len_d > {2'b00, cfg_i.max_tld}))) begin
      reason_d = RSN_TLD;
    end else if (bad_d) begin
      reason_d = RSN_BAD_CHAR;
    end else begin
      reason_d = RSN_OK;
    end
  end

  // State registers; cleared after each verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q    <= 8'd0;
      label_len_q   <= 8'd0;
      dot_cnt_q     <= 4'd0;
      drun_q        <= 4'd0;
      drun_max_q    <= 4'd0;
      saw_dot_q     <= 1'b0;
      lbl_letters_q <= 1'b1;
      all_digits_q  <= 1'b1;
      rsv_q         <= '1;
      edge_q        <= 1'b0;
      strct_q       <= 1'b0;
      strct_dots_q  <= 1'b0;
      non_ascii_q   <= 1'b0;
      bad_q         <= 1'b0;
      prev_dot_q    <= 1'b0;
    end else if (pop_o) begin
      if (item_i.is_last) begin
        name_len_q    <= 8'd0;
        label_len_q   <= 8'd0;
        dot_cnt_q     <= 4'd0;
        drun_q        <= 4'd0;
        drun_max_q    <= 4'd0;
        saw_dot_q     <= 1'b0;
        lbl_letters_q <= 1'b1;
        all_digits_q  <= 1'b1;
        rsv_q         <= '1;
        edge_q        <= 1'b0;
        strct_q       <= 1'b0;
        strct_dots_q  <= 1'b0;
        non_ascii_q   <= 1'b0;
        bad_q         <= 1'b0;
        prev_dot_q    <= 1'b0;
      end else begin
        name_len_q    <= name_len_d;
        label_len_q   <= label_len_d;
        dot_cnt_q     <= dot_cnt_d;
        drun_q        <= drun_d;
        drun_max_q    <= drun_max_d;
        saw_dot_q     <= saw_dot_d;
        lbl_letters_q <= lbl_letters_d;
        all_digits_q  <= all_digits_d;
        rsv_q         <= rsv_d;
        edge_q        <= edge_d;
        strct_q       <= strct_d;
        strct_dots_q  <= strct_dots_d;
        non_ascii_q   <= non_ascii_d;
        bad_q         <= bad_d;
        prev_dot_q    <= prev_dot_d;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && item_i.is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.is_last) begin
      reason_q     <= reason_d;
      name_valid_q <= (reason_d == RSN_OK);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign name_valid_o  = name_valid_q;
  assign fail_reason_o = reason_q;

endmodule

`default_nettype wire

>>> design/domain_name_validator_core.sv
// Top level of the domain name validator: configuration registers and the
// front end, queue and back end. Depends on dnv_pkg, dnv_front, dnv_queue, dnv_back.
`default_nettype none

// A domain name enters one byte per word, is_last set on its final byte, at
// up to one word per clock. Each word is classified in the front end, parked
// in a two-entry queue and folded into the running counters by the back end.
// The verdict (name_valid, fail_reason) is loaded into the output register at
// the edge where the back end takes the final byte from the queue; bytes
// without is_last give no result. Input ready drops only when the queue is
// full, which happens when a verdict waits in the output register, the next
// final byte sits at the head of the queue and one more word arrives behind
// it. Configuration registers are written with cfg_we_i at any edge but
// should change only between names.

module domain_name_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] name_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       name_valid_o,
  output logic [3:0] fail_reason_o
);
  import dnv_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push, pop, q_full, q_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_name  <= MAX_NAME_RST;
      cfg_q.max_label <= MAX_LABEL_RST;
      cfg_q.max_dots  <= MAX_DOTS_RST;
      cfg_q.max_drun  <= MAX_DRUN_RST;
      cfg_q.max_tld   <= MAX_TLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_NAME:  cfg_q.max_name  <= cfg_wdata_i;
        CFG_MAX_LABEL: cfg_q.max_label <= cfg_wdata_i[6:0];
        CFG_MAX_DOTS:  cfg_q.max_dots  <= cfg_wdata_i[3:0];
        CFG_MAX_DRUN:  cfg_q.max_drun  <= cfg_wdata_i[3:0];
        CFG_MAX_TLD:   cfg_q.max_tld   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  dnv_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .name_byte_i (name_byte_i),
    .is_last_i   (is_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  dnv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  dnv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .name_valid_o  (name_valid_o),
    .fail_reason_o (fail_reason_o)
  );

endmodule

`default_nettype wire

>>> bench/domain_name_validator_core_tb.sv
// Self-checking bench for domain_name_validator_core: random and directed names,
// each byte predicted and each verdict compared against a built-in predictor.
// Depends on dnv_pkg and the domain_name_validator_core RTL.
`default_nettype none

module domain_name_validator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnv_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS = 40;
  localparam logic [7:0] DOT = 8'h2E;
  localparam logic [7:0] HYPHEN = 8'h2D;
  localparam logic [7:0] UNDERSCORE = 8'h5F;
  localparam int TLD_CEILING = 63;

  typedef struct packed {
    logic [7:0] nb;
    logic       last;
  } name_word_t;

  typedef struct packed {
    logic    ok;
    reason_e why;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] name_byte_i;
  logic       is_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       name_valid_o;
  logic [3:0] fail_reason_o;

  domain_name_validator_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .name_byte_i  (name_byte_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .name_valid_o (name_valid_o),
    .fail_reason_o(fail_reason_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Bench state
  name_word_t bytes_to_send[$];
  verdict_t   verdicts_due[$];
  logic [7:0] name_buf[$];
  string      rsv_words[6] = '{"localhost", "local", "test", "invalid", "example", "onion"};

  bit in_fire, out_fire;
  bit send_idle, recv_idle;
  int send_gap, recv_wait;
  int stall_len, stall_seq, stall_seen, stall_left;
  int errors, prints, cycles;
  int bytes_queued, names_queued, settings_used;
  int verdicts_seen[9];

  // Predictor: configuration copy and per-name running state
  cfg_t       limits;
  logic [7:0] prev_byte;
  logic [5:0] rsv_alive;
  int name_len, label_len, dot_cnt, dig_run, dig_run_max;
  bit saw_dot_q, label_alpha, digits_only;
  bit lead_edge, struct_bad, struct_by_dots, high_byte, odd_char;

  function automatic bit ascii_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit ascii_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // First structural failure wins; later ones do not change the code
  function automatic void note_structure(bit by_dots);
    if (!struct_bad) begin
      struct_bad = 1'b1;
      struct_by_dots = by_dots;
    end
  endfunction

  task automatic restart_name();
    name_len = 0;
    label_len = 0;
    dot_cnt = 0;
    dig_run = 0;
    dig_run_max = 0;
    saw_dot_q = 1'b0;
    label_alpha = 1'b1;
    digits_only = 1'b1;
    rsv_alive = '1;
    lead_edge = 1'b0;
    struct_bad = 1'b0;
    struct_by_dots = 1'b0;
    high_byte = 1'b0;
    odd_char = 1'b0;
    prev_byte = 8'h00;
  endtask

  // Fold one accepted word into the running state; on the last byte,
  // produce the verdict and start over
  task automatic absorb_byte(input logic [7:0] c, input logic last,
                             output bit has_verdict, output verdict_t v);
    reason_e why;
    bit rsv_hit;
    int i;
    has_verdict = 1'b0;
    v = '0;
    if (name_len == 0 && (c == DOT || c == HYPHEN)) lead_edge = 1'b1;
    if (name_len < 255) name_len++;
    if (c == DOT) begin
      if (label_len == 0 || label_len > limits.max_label) note_structure(1'b0);
      label_len = 0;
      if (dot_cnt < 15) dot_cnt++;
      if (dot_cnt > limits.max_dots) note_structure(1'b1);
      dig_run = 0;
      saw_dot_q = 1'b1;
      label_alpha = 1'b1;
      rsv_alive = '1;
      if (prev_byte == DOT && name_len > 1) odd_char = 1'b1;
    end else begin
      for (i = 0; i < 6; i++) begin
        if (label_len >= rsv_words[i].len() || rsv_words[i][label_len] != c)
          rsv_alive[i] = 1'b0;
      end
      if (label_len < 255) label_len++;
      if (ascii_digit(c)) begin
        if (dig_run < 15) dig_run++;
        if (dig_run > dig_run_max) dig_run_max = dig_run;
      end else begin
        digits_only = 1'b0;
        dig_run = 0;
      end
      if (!ascii_letter(c)) label_alpha = 1'b0;
      if (c > 8'd127) high_byte = 1'b1;
      if (!ascii_letter(c) && !ascii_digit(c) && c != HYPHEN) odd_char = 1'b1;
    end
    prev_byte = c;

    if (last) begin
      if (label_len == 0 || label_len > limits.max_label) note_structure(1'b0);
      rsv_hit = 1'b0;
      for (i = 0; i < 6; i++)
        if (rsv_alive[i] && label_len == rsv_words[i].len()) rsv_hit = 1'b1;
      if (name_len > limits.max_name)
        why = RSN_LENGTH;
      else if (lead_edge || c == DOT || c == HYPHEN)
        why = RSN_EDGE;
      else if (struct_bad)
        why = struct_by_dots ? RSN_DOTS : RSN_LABEL;
      else if (rsv_hit)
        why = RSN_RESERVED;
      else if (high_byte || digits_only || dig_run_max > limits.max_drun)
        why = RSN_SUSPICIOUS;
      else if (saw_dot_q && (label_len < 2 || label_len > TLD_CEILING || !label_alpha ||
                             label_len > limits.max_tld))
        why = RSN_TLD;
      else if (odd_char)
        why = RSN_BAD_CHAR;
      else
        why = RSN_OK;
      v.ok = (why == RSN_OK);
      v.why = why;
      has_verdict = 1'b1;
      restart_name();
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("%0t: MISMATCH %s got %0d want %0d", $realtime, what, got, want);
    end
  endtask

  // Sample both handshakes, predict accepted words, check delivered verdicts
  always @(posedge clk_i) begin
    bit       got_one;
    verdict_t v;
    verdict_t want;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (out_fire) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected verdict, reason", 8'(fail_reason_o), 8'd0);
      end else begin
        want = verdicts_due.pop_front();
        if (name_valid_o !== want.ok)
          report_mismatch("name_valid", 8'(name_valid_o), 8'(want.ok));
        if (fail_reason_o !== want.why)
          report_mismatch("fail_reason", 8'(fail_reason_o), 8'(want.why));
        verdicts_seen[int'(want.why)]++;
      end
    end
    if (in_fire) begin
      absorb_byte(name_byte_i, is_last_i, got_one, v);
      if (got_one) verdicts_due.push_back(v);
    end
  end

  // Byte driver: random gap before each word while send_idle is set, valid held until accepted
  always @(negedge clk_i) begin
    name_word_t w;
    if (rst_ni) begin
      if (in_fire) send_gap = send_idle ? $urandom_range(0, 6) : 0;
      if (!in_valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          w = bytes_to_send.pop_front();
          name_byte_i <= w.nb;
          is_last_i <= w.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Verdict receiver: random wait per verdict while recv_idle is set, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) recv_wait = recv_idle ? $urandom_range(0, 6) : 0;
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        stall_left = stall_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d verdicts still due", $realtime, verdicts_due.size());
      $display("domain_name_validator_core_tb NOT OK");
      $finish;
    end
  end

  // Stimulus helpers
  task automatic flush_name();
    int i;
    name_word_t w;
    for (i = 0; i < name_buf.size(); i++) begin
      w.nb = name_buf[i];
      w.last = (i == name_buf.size() - 1);
      bytes_to_send.push_back(w);
    end
    bytes_queued += name_buf.size();
    names_queued++;
    name_buf.delete();
  endtask

  task automatic put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // mode 0: letters, 1-2: letters/digits/hyphen, 3: digits
  function automatic logic [7:0] label_char(int mode);
    int r;
    r = $urandom_range(0, 25);
    if (mode == 3 || (mode != 0 && $urandom_range(0, 3) == 0))
      return 8'h30 + 8'($urandom_range(0, 9));
    if (mode != 0 && $urandom_range(0, 9) == 0) return HYPHEN;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(r);
  endfunction

  // Mostly short labels, some around 63 and a few around 127
  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 10);
    if (r < 90) return $urandom_range(11, 30);
    if (r < 97) return $urandom_range(55, 70);
    return $urandom_range(120, 135);
  endfunction

  task automatic make_random_name();
    int kind, labels, len, i, pos, target;
    string w;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // raw noise, any byte value
      len = $urandom_range(1, 8);
      repeat (len) name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 11) begin
      // long name across the length limit and the 255 saturation point
      target = $urandom_range(230, 300);
      while (name_buf.size() < target) begin
        len = $urandom_range(30, 62);
        repeat (len) name_buf.push_back(label_char(0));
        name_buf.push_back(DOT);
      end
      repeat ($urandom_range(2, 6)) name_buf.push_back(label_char(0));
    end else begin
      labels = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 3);
      for (i = 0; i < labels; i++) begin
        len = pick_label_len();
        repeat (len) name_buf.push_back(label_char($urandom_range(0, 3)));
        name_buf.push_back(DOT);
      end
      // final label
      kind = $urandom_range(0, 99);
      w = rsv_words[$urandom_range(0, 5)];
      if (kind < 8) begin
        put_text(w);
      end else if (kind < 13) begin
        // near misses of a reserved word
        case ($urandom_range(0, 2))
          0: put_text(w.substr(0, w.len() - 2));
          1: begin
            put_text(w);
            name_buf.push_back(label_char(0));
          end
          default: put_text(w.toupper());
        endcase
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 12)) name_buf.push_back(label_char(3));
      end else if (kind < 28) begin
        repeat (pick_label_len()) name_buf.push_back(label_char(1));
      end else if (kind < 33) begin
        repeat ($urandom_range(15, 70)) name_buf.push_back(label_char(0));
      end else begin
        repeat ($urandom_range(1, 8)) name_buf.push_back(label_char(0));
      end

      // damage some names
      if ($urandom_range(0, 99) < 30) begin
        pos = $urandom_range(0, name_buf.size());
        case ($urandom_range(0, 5))
          0: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
          1: name_buf.insert(pos, DOT);
          2: name_buf.push_front($urandom_range(0, 1) ? DOT : HYPHEN);
          3: name_buf.push_back($urandom_range(0, 1) ? DOT : HYPHEN);
          4: repeat ($urandom_range(1, 16)) name_buf.insert(pos, label_char(3));
          default: name_buf[$urandom_range(0, name_buf.size() - 1)] =
                     $urandom_range(0, 1) ? HYPHEN : UNDERSCORE;
        endcase
      end
    end
    flush_name();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_MAX_NAME:  limits.max_name = val;
      CFG_MAX_LABEL: limits.max_label = val[6:0];
      CFG_MAX_DOTS:  limits.max_dots = val[3:0];
      CFG_MAX_DRUN:  limits.max_drun = val[3:0];
      CFG_MAX_TLD:   limits.max_tld = val[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_limits(int nm, int lbl, int dots, int drun, int tld);
    write_reg(CFG_MAX_NAME, 8'(nm));
    write_reg(CFG_MAX_LABEL, 8'(lbl));
    write_reg(CFG_MAX_DOTS, 8'(dots));
    write_reg(CFG_MAX_DRUN, 8'(drun));
    write_reg(CFG_MAX_TLD, 8'(tld));
    settings_used++;
  endtask

  // Sender holds back until every verdict is in and the block has settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (bytes_to_send.size() != 0 || in_valid_i || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int budget, bit s_idle, bit r_idle);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = bytes_queued;
    while (bytes_queued - start < budget) make_random_name();
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    name_byte_i = '0;
    is_last_i = 1'b0;
    out_ready_i = 1'b0;
    limits = '{8'd253, 7'd63, 4'd10, 4'd8, 6'd20};
    restart_name();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    settings_used = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed names under reset limits: one per verdict class where short
    put_text("a.bc");  flush_name();  // accepted
    put_text("a");     flush_name();  // single letter, no dot
    put_text("-");     flush_name();  // leading hyphen
    put_text("a.");    flush_name();  // trailing dot
    put_text("a..bc"); flush_name();  // empty label
    put_text("test");  flush_name();  // reserved word
    put_text("1");     flush_name();  // digits only
    name_buf.push_back(8'hFF); flush_name();  // non-ASCII byte
    put_text("a.b");   flush_name();  // final label too short
    put_text("_");     flush_name();  // disallowed character
    name_buf.push_back(8'h00); flush_name();  // NUL byte
    wait_idle();

    random_phase(250, 1'b1, 1'b1);

    // lowest limits, no idling on either side
    set_limits(1, 1, 0, 1, 2);
    random_phase(150, 1'b0, 1'b0);

    // widest limits, including the values that disable the saturating checks
    set_limits(255, 127, 15, 15, 63);
    random_phase(250, 1'b1, 1'b1);

    // tight limits while the receiver holds off for a long stretch
    set_limits(40, 12, 3, 4, 6);
    stall_len = 400;
    stall_seq++;
    random_phase(300, 1'b0, 1'b1);

    set_limits(254, 127, 14, 14, 63);
    random_phase(200, 1'b1, 1'b0);

    repeat (2) begin
      set_limits($urandom_range(1, 254), $urandom_range(1, 127), $urandom_range(0, 14),
                 $urandom_range(1, 14), $urandom_range(2, 63));
      random_phase(200, 1'b1, 1'b1);
    end

    set_limits(253, 63, 10, 8, 20);
    random_phase(100, 1'b1, 1'b1);

    $display("Checked %0d names (%0d bytes) under %0d limit settings.",
             names_queued, bytes_queued, settings_used);
    $display("Verdicts ok/len/edge/label/dots/rsv/susp/tld/char: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
             verdicts_seen[4], verdicts_seen[5], verdicts_seen[6], verdicts_seen[7],
             verdicts_seen[8]);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("domain_name_validator_core_tb OK");
    end else begin
      $display("domain_name_validator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
